// ===== rtl/epsc_pkg.sv =====
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared types, constants and the period table for the encoder PWM controller.
// ----------------------------------------------------------------------------
`default_nettype none

package epsc_pkg;

    // Default of the period table depth
    localparam int TABLE_DEPTH_DEF = 14;

    // Field widths
    localparam int IN_DATA_W  = 16;  // 11 payload bits padded to bytes
    localparam int OUT_DATA_W = 48;  // 47 payload bits padded to bytes
    localparam int COUNT_W    = 16;
    localparam int CLKSEL_W   = 3;
    localparam int INDEX_W    = 4;
    localparam int LEVEL_W    = 7;
    localparam int POT_W      = 8;

    // Quadrature transition codes: {previous pair, new pair}
    localparam logic [3:0] ENC_UP_RISE   = 4'b0001;
    localparam logic [3:0] ENC_UP_FALL   = 4'b1110;
    localparam logic [3:0] ENC_DOWN_RISE = 4'b0010;
    localparam logic [3:0] ENC_DOWN_FALL = 4'b1101;

    // Clock select codes
    localparam logic [CLKSEL_W-1:0] CLKSEL_DIV1    = 3'd1;
    localparam logic [CLKSEL_W-1:0] CLKSEL_DIV8    = 3'd2;
    localparam logic [CLKSEL_W-1:0] CLKSEL_DIV1024 = 3'd5;

    // Adjust modes
    typedef enum logic {
        MODE_WAVE      = 1'b0,
        MODE_PRESCALER = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // Reset values
    localparam logic [INDEX_W-1:0] INDEX_RST  = 4'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_RST  = 7'd64;
    localparam logic [COUNT_W-1:0] PERIOD_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] DUTY_RST   = 16'd500;

    function automatic step_t decode_step(input logic [1:0] prev_pair,
                                          input logic [1:0] new_pair);
        logic [3:0] code;
        step_t      step;
        code = {prev_pair, new_pair};
        step = STEP_NONE;
        if (code == ENC_UP_RISE || code == ENC_UP_FALL) begin
            step = STEP_UP;
        end else if (code == ENC_DOWN_RISE || code == ENC_DOWN_FALL) begin
            step = STEP_DOWN;
        end
        return step;
    endfunction

    // Timer top value per period index; entries past the thirteenth read as 2
    function automatic logic [COUNT_W-1:0] period_lookup(input logic [INDEX_W-1:0] idx);
        logic [COUNT_W-1:0] val;
        unique case (idx)
            4'd0:    val = 16'd50000;
            4'd1:    val = 16'd20000;
            4'd2:    val = 16'd10000;
            4'd3:    val = 16'd5000;
            4'd4:    val = 16'd2000;
            4'd5:    val = 16'd1000;
            4'd6:    val = 16'd500;
            4'd7:    val = 16'd200;
            4'd8:    val = 16'd100;
            4'd9:    val = 16'd50;
            4'd10:   val = 16'd20;
            4'd11:   val = 16'd10;
            4'd12:   val = 16'd5;
            default: val = 16'd2;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/encoder_pwm_setting_controller_top.sv =====
// ----------------------------------------------------------------------------
// encoder_pwm_setting_controller_top
// Quadrature encoder and pot driven PWM period / duty / prescaler settings.
// ----------------------------------------------------------------------------
// One input transfer per tick carries both encoder pins, a debounced switch
// press and a pot sample; one result transfer per input reports the settings
// after that tick. A press toggles between wave mode (encoder moves the period
// index, pot sets the duty) and prescaler mode (encoder moves the clock
// select, counts hold). Throughput is one transfer per clock while m_tready
// keeps up: an input register feeds combinational update logic (table
// lookup plus a 16x7 multiply) that writes the setting registers, and those
// registers are the result register, so m_tvalid rises once the input
// register's contents are applied, which waits while a result is held.
// While a result waits for m_tready, one more input is still taken into the
// input register.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pwm_setting_controller_top
    import epsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF  // 2..16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    // Input stream
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // [0] enc_a, [1] enc_b, [2] switch_press, [10:3] pot_sample
    input  wire  [IN_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // [15:0] period_count, [31:16] duty_count, [34:32] clock_select,
    // [35] mode_now, [39:36] period_index, [46:40] duty_level_out
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    localparam logic [INDEX_W-1:0] INDEX_MAX = INDEX_W'(TABLE_DEPTH - 1);

    // Input register
    logic               in_valid_reg, in_valid_next;
    logic               enc_a_reg, enc_b_reg, press_reg;
    logic [POT_W-1:0]   pot_reg;

    // Setting registers, which double as the result register
    logic                  out_valid_reg, out_valid_next;
    mode_t                 mode_reg, mode_next;
    logic [1:0]            enc_prev_reg, enc_prev_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [CLKSEL_W-1:0]   clksel_reg, clksel_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [COUNT_W-1:0]    period_reg, period_next;
    logic [COUNT_W-1:0]    duty_reg, duty_next;

    logic                  out_free;
    logic                  advance;
    logic                  in_fire;
    step_t                 step;
    logic [INDEX_W:0]      index_cand;
    logic [COUNT_W+LEVEL_W-1:0] duty_prod;
    logic [COUNT_W-1:0]    duty_scaled;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            enc_a_reg <= s_tdata[0];
            enc_b_reg <= s_tdata[1];
            press_reg <= s_tdata[2];
            pot_reg   <= s_tdata[10:3];
        end
    end

    // Update logic: press applies first, then the encoder step
    always_comb begin
        mode_next     = mode_reg;
        enc_prev_next = enc_prev_reg;
        index_next    = index_reg;
        clksel_next   = clksel_reg;
        level_next    = level_reg;
        period_next   = period_reg;
        duty_next     = duty_reg;
        out_valid_next = out_valid_reg && !m_tready;
        index_cand    = {1'b0, index_reg};
        duty_prod     = '0;
        duty_scaled   = '0;
        step          = decode_step(enc_prev_reg, {enc_b_reg, enc_a_reg});

        if (advance) begin
            out_valid_next = 1'b1;
            mode_next      = press_reg ? mode_t'(~mode_reg) : mode_reg;
            enc_prev_next  = {enc_b_reg, enc_a_reg};

            if (mode_next == MODE_WAVE) begin
                unique case (step)
                    STEP_UP:   index_cand = {1'b0, index_reg} + 1'b1;
                    STEP_DOWN: index_cand = (index_reg == '0) ? '0
                                          : {1'b0, index_reg} - 1'b1;
                    default:   index_cand = {1'b0, index_reg};
                endcase
                // clamp on every wave-mode update: covers a reset index past a short table
                index_next  = (index_cand > {1'b0, INDEX_MAX}) ? INDEX_MAX
                            : index_cand[INDEX_W-1:0];
                level_next  = pot_reg[POT_W-1:1];
                period_next = period_lookup(index_next);
                duty_prod   = period_next * level_next;
                duty_scaled = duty_prod[COUNT_W+LEVEL_W-1:LEVEL_W];
                duty_next   = (duty_scaled == '0) ? COUNT_W'(1) : duty_scaled;
            end else begin
                unique case (step)
                    STEP_UP:   clksel_next = (clksel_reg >= CLKSEL_DIV1024)
                                           ? CLKSEL_DIV1024 : clksel_reg + 1'b1;
                    STEP_DOWN: clksel_next = (clksel_reg <= CLKSEL_DIV1)
                                           ? CLKSEL_DIV1 : clksel_reg - 1'b1;
                    default:   clksel_next = clksel_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_WAVE;
            enc_prev_reg  <= 2'b00;
            index_reg     <= INDEX_RST;
            clksel_reg    <= CLKSEL_DIV8;
            level_reg     <= LEVEL_RST;
            period_reg    <= PERIOD_RST;
            duty_reg      <= DUTY_RST;
        end else begin
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            enc_prev_reg  <= enc_prev_next;
            index_reg     <= index_next;
            clksel_reg    <= clksel_next;
            level_reg     <= level_next;
            period_reg    <= period_next;
            duty_reg      <= duty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, level_reg, index_reg, mode_reg, clksel_reg,
                       duty_reg, period_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_clksel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        clksel_reg >= CLKSEL_DIV1 && clksel_reg <= CLKSEL_DIV1024)
        else $error("clock select out of range");

    a_duty_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg != '0)
        else $error("duty count is zero");

    a_index_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && mode_reg == MODE_WAVE |-> index_reg <= INDEX_MAX)
        else $error("period index beyond table");

    a_prescaler_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode_next == MODE_PRESCALER |=>
            $stable(period_reg) && $stable(duty_reg) && $stable(index_reg))
        else $error("counts changed in prescaler mode");

    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("update did not produce a result");

endmodule

`default_nettype wire
